FILE: rtl/core/sdp_pkg.sv
`default_nettype none
package sdp_pkg;

	typedef struct packed {
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic               final_neighbour;
	} sdp_in_t;

	typedef struct packed {
		logic        [31:0] density;
		logic signed [47:0] pressure;
	} sdp_out_t;

	// one classified offset: h2 - r2 inside the radius, zero outside
	typedef struct packed {
		logic [23:0] margin;
		logic        final_neighbour;
	} sdp_work_t;

	localparam logic [1:0] CfgKernelRadiusSq = 2'd0;
	localparam logic [1:0] CfgMassPoly6Coef  = 2'd1;
	localparam logic [1:0] CfgGasStiffness   = 2'd2;
	localparam logic [1:0] CfgRestDensity    = 2'd3;

	localparam logic [23:0] KernelRadiusSqReset = 24'd65536;
	localparam logic [31:0] MassPoly6CoefReset  = 32'd53404000;
	localparam logic [15:0] GasStiffnessReset   = 16'd2000;
	localparam logic [31:0] RestDensityReset    = 32'd19660800;

	localparam logic [31:0]        DensityMax  = 32'hFFFF_FFFF;
	localparam logic signed [47:0] PressureMax = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] PressureMin = 48'sh8000_0000_0000;

endpackage
`default_nettype wire

FILE: rtl/core/sph_density_pressure.sv
// An accepted final offset passes the front register, the queue and the back pipeline.
// One offset per cycle unless queue is full; the saturating density sum is loop-carried.
// A 4-entry queue between classifier and kernel pipeline absorbs result stalls.
// Reset: clears the density sum, all valids and the queue; the config takes its defaults.
`default_nettype none
module sph_density_pressure #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire sdp_pkg::sdp_in_t  item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output sdp_pkg::sdp_out_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [31:0]       cfg_data
);

	logic [23:0] kernel_radius_sq_q;
	logic [31:0] mass_poly6_coef_q;
	logic [15:0] gas_stiffness_q;
	logic [31:0] base_density_q;

	logic               push;
	logic               full;
	logic               pop;
	logic               empty;
	sdp_pkg::sdp_work_t push_data;
	sdp_pkg::sdp_work_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_radius_sq_q <= sdp_pkg::KernelRadiusSqReset;
			mass_poly6_coef_q  <= sdp_pkg::MassPoly6CoefReset;
			gas_stiffness_q    <= sdp_pkg::GasStiffnessReset;
			base_density_q     <= sdp_pkg::RestDensityReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sdp_pkg::CfgKernelRadiusSq: kernel_radius_sq_q <= cfg_data[23:0];
				sdp_pkg::CfgMassPoly6Coef:  mass_poly6_coef_q  <= cfg_data;
				sdp_pkg::CfgGasStiffness:   gas_stiffness_q    <= cfg_data[15:0];
				sdp_pkg::CfgRestDensity:    base_density_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sdp_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.item             (item),
		.kernel_radius_sq (kernel_radius_sq_q),
		.push             (push),
		.push_data        (push_data),
		.full             (full)
	);

	sdp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	sdp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.empty           (empty),
		.head            (head),
		.pop             (pop),
		.mass_poly6_coef (mass_poly6_coef_q),
		.gas_stiffness   (gas_stiffness_q),
		.base_density    (base_density_q),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result          (result)
	);

endmodule
`default_nettype wire

FILE: rtl/core/sdp_front.sv
`default_nettype none
module sdp_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire sdp_pkg::sdp_in_t   item,
	input  wire logic [23:0]        kernel_radius_sq,
	output logic                    push,
	output sdp_pkg::sdp_work_t      push_data,
	input  wire logic               full
);

	logic        valid_s1;
	logic [31:0] sqx_s1;
	logic [31:0] sqy_s1;
	logic        fin_s1;
	logic [15:0] ax;
	logic [15:0] ay;
	logic [31:0] r2;
	logic        take;

	assign ax = item.delta_x[15] ? 16'(~item.delta_x + 16'd1) : 16'(item.delta_x);
	assign ay = item.delta_y[15] ? 16'(~item.delta_y + 16'd1) : 16'(item.delta_y);

	assign push       = valid_s1 && !full;
	assign item_stall = valid_s1 && full;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sqx_s1 <= ax * ax;
			sqy_s1 <= ay * ay;
			fin_s1 <= item.final_neighbour;
		end
	end

	// r2 is at most 2^31, so the 32-bit sum is exact
	assign r2 = sqx_s1 + sqy_s1;

	always_comb begin
		push_data.final_neighbour = fin_s1;
		if (r2 < {8'd0, kernel_radius_sq}) begin
			push_data.margin = kernel_radius_sq - r2[23:0];
		end else begin
			push_data.margin = 24'd0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/sdp_queue.sv
`default_nettype none
module sdp_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire sdp_pkg::sdp_work_t push_data,
	output logic                    full,
	input  wire logic               pop,
	output sdp_pkg::sdp_work_t      head,
	output logic                    empty
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	sdp_pkg::sdp_work_t mem_q [DEPTH];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    count_q;

	assign full  = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/sdp_back.sv
`default_nettype none
module sdp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               empty,
	input  wire sdp_pkg::sdp_work_t head,
	output logic                    pop,
	input  wire logic [31:0]        mass_poly6_coef,
	input  wire logic [15:0]        gas_stiffness,
	input  wire logic [31:0]        base_density,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output sdp_pkg::sdp_out_t       result
);

	logic adv;

	logic         v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic         f_s1, f_s2, f_s3, f_s4, f_s5, f_s6;
	logic [23:0]  d_s1, d_s2;
	logic [47:0]  d2_s2;
	logic [47:0]  pl_s3, ph_s3;
	logic [71:0]  d3_s4;
	logic [55:0]  q0_s5, q1_s5, q2_s5;
	logic [79:0]  a_s6;
	logic [55:0]  q2_s6;
	logic [31:0]  dens_s7, dens_s8;
	logic signed [49:0] prod_s8;
	logic [31:0]  sum_q;
	logic         out_valid_q;
	sdp_pkg::sdp_out_t out_q;

	logic [103:0] full_prod;
	logic [39:0]  add;
	logic [40:0]  sum_total;
	logic [31:0]  sum_sat;
	logic signed [32:0] diff;
	logic signed [16:0] gas_s;
	logic signed [49:0] prod;
	logic signed [47:0] press_sat;

	assign adv = !out_valid_q || !result_stall;
	assign pop = !empty && adv;

	assign full_prod = {24'd0, a_s6} + {q2_s6, 48'd0};
	assign add       = full_prod[103:64];
	assign sum_total = {9'd0, sum_q} + {1'b0, add};
	assign sum_sat   = (sum_total[40:32] != 9'd0) ? sdp_pkg::DensityMax : sum_total[31:0];

	assign diff  = $signed({1'b0, dens_s7}) - $signed({1'b0, base_density});
	assign gas_s = $signed({1'b0, gas_stiffness});
	assign prod  = diff * gas_s;

	always_comb begin
		if (prod_s8[49:47] == 3'b000 || prod_s8[49:47] == 3'b111) begin
			press_sat = prod_s8[47:0];
		end else if (prod_s8[49]) begin
			press_sat = sdp_pkg::PressureMin;
		end else begin
			press_sat = sdp_pkg::PressureMax;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			out_valid_q <= 1'b0;
			sum_q       <= '0;
		end else if (adv) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6 && f_s6;
			v_s8        <= v_s7;
			out_valid_q <= v_s8;
			if (v_s6) begin
				sum_q <= f_s6 ? 32'd0 : sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1    <= head.margin;
			f_s1    <= head.final_neighbour;
			d2_s2   <= d_s1 * d_s1;
			d_s2    <= d_s1;
			f_s2    <= f_s1;
			pl_s3   <= d2_s2[23:0] * d_s2;
			ph_s3   <= d2_s2[47:24] * d_s2;
			f_s3    <= f_s2;
			d3_s4   <= {ph_s3, 24'd0} + {24'd0, pl_s3};
			f_s4    <= f_s3;
			q0_s5   <= mass_poly6_coef * d3_s4[23:0];
			q1_s5   <= mass_poly6_coef * d3_s4[47:24];
			q2_s5   <= mass_poly6_coef * d3_s4[71:48];
			f_s5    <= f_s4;
			a_s6    <= {24'd0, q0_s5} + {q1_s5, 24'd0};
			q2_s6   <= q2_s5;
			f_s6    <= f_s5;
			dens_s7 <= sum_sat;
			dens_s8 <= dens_s7;
			prod_s8 <= prod;
			out_q.density  <= dens_s8;
			out_q.pressure <= press_sat;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire
